// File: rtl/assert_macros.svh
// Assertion macros shared by the ownership table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ROTT_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ROTT_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  `ROTT_ASSERT(name, clk, rstn, !(cond), msg)

`endif

// File: rtl/rott_pkg.sv
// Types and constants of the ring ownership token table.
// No dependencies; imported by every module of the block but rott_ram.
package rott_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_XFER  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_XFER  = 2'd2,
    KIND_FAIL  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ring;
    logic [7:0]  tok_owner;
    logic [31:0] tok_gen;
    logic [63:0] tok_epoch;
    logic [7:0]  new_owner;
    logic [31:0] new_gen;
  } req_t;

  typedef struct packed {
    logic [63:0] epoch;
    logic [31:0] gen;
    logic [7:0]  owner;
  } entry_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  ring;
    logic [7:0]  owner;
    logic [31:0] gen;
    logic [63:0] epoch;
  } res_t;

  localparam int unsigned EntryW = $bits(entry_t);

  localparam logic [63:0] EPOCH_STEP  = 64'd2;
  localparam logic [63:0] EPOCH_LIMIT = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] RESET_EPOCH = 64'd2;
  localparam logic [31:0] RESET_GEN   = 32'd1;

endpackage

// File: rtl/rott_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the ownership entry store.
module rott_ram #(
  parameter int unsigned WIDTH = 104,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rott_fifo.sv
// Two-entry request queue between the classifier and the table engine.
// Depends on rott_pkg (req_t) and assert_macros.svh.
`include "assert_macros.svh"
module rott_fifo
  import rott_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic pop_i,
  output req_t req_o,
  output logic empty_o
);

  req_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= req_i;
    end
  end

  assign req_o   = slot_q[rptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

  `ROTT_ASSERT_NEVER(a_fifo_pop_empty, clk_i, rst_ni, pop_i && (cnt_q == 2'd0), "pop while empty")
  `ROTT_ASSERT(a_fifo_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")

endmodule

// File: rtl/rott_front.sv
// Intake stage: unpacks the input transaction, validates arguments, classifies it.
// Depends on rott_pkg (action_e, kind_e, req_t, EPOCH_LIMIT).
module rott_front
  import rott_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 8
) (
  input  logic         s_tvalid_i,
  input  logic [159:0] s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         full_i,
  output logic         s_tready_o,
  output logic         push_o,
  output req_t         req_o
);

  localparam logic [7:0] MaxW = 8'(MAX_WORKERS);

  logic [7:0]  ring;
  logic [7:0]  tok_ring;
  logic [63:0] tok_epoch;
  logic [7:0]  new_owner;
  logic [31:0] new_gen;
  logic        ring_ok;
  logic        tok_ring_ok;
  logic        xfer_args_ok;

  assign ring      = s_tdata_i[7:0];
  assign tok_ring  = s_tdata_i[15:8];
  assign tok_epoch = s_tdata_i[119:56];
  assign new_owner = s_tdata_i[127:120];
  assign new_gen   = s_tdata_i[159:128];

  assign ring_ok      = (ring < MaxW);
  assign tok_ring_ok  = (tok_ring < MaxW);
  assign xfer_args_ok = ring_ok && (tok_ring == ring) && (new_owner < MaxW) &&
                        (new_gen != 32'd0) && !tok_epoch[0] &&
                        (tok_epoch <= EPOCH_LIMIT);

  always_comb begin
    req_o.ring      = ring;
    req_o.tok_owner = s_tdata_i[23:16];
    req_o.tok_gen   = s_tdata_i[55:24];
    req_o.tok_epoch = tok_epoch;
    req_o.new_owner = new_owner;
    req_o.new_gen   = new_gen;
    unique case (s_tuser_i)
      ACT_READ: begin
        req_o.kind = ring_ok ? KIND_READ : KIND_FAIL;
      end
      ACT_CHECK: begin
        req_o.kind = tok_ring_ok ? KIND_CHECK : KIND_FAIL;
        req_o.ring = tok_ring;
      end
      ACT_XFER: begin
        req_o.kind = xfer_args_ok ? KIND_XFER : KIND_FAIL;
      end
      default: begin
        req_o.kind = KIND_FAIL;
      end
    endcase
  end

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

endmodule

// File: rtl/rott_back.sv
// Table engine: reads the entry, compares the token, updates, registers the result.
// Depends on rott_pkg, rott_ram and assert_macros.svh.
`include "assert_macros.svh"
module rott_back
  import rott_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  req_t req_i,
  output logic pop_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output res_t res_o
);

  localparam int unsigned IW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam logic [7:0]  MaxW = 8'(MAX_WORKERS);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                   state_q, state_d;
  req_t                   req_q;
  logic [MAX_WORKERS-1:0] vld_q, vld_d;
  logic                   m_valid_q, m_valid_d;
  res_t                   res_q, res_d;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          raddr;
  logic [EntryW-1:0]      rdata;
  entry_t                 rd_entry;
  entry_t                 cur;
  entry_t                 wentry;
  logic                   we;
  logic                   out_free;
  logic                   sane;
  logic                   match;
  logic [63:0]            next_epoch;

  assign idx      = req_q.ring[IW-1:0];
  assign raddr    = req_i.ring[IW-1:0];
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign out_free = !m_valid_q || m_tready_i;
  assign rd_entry = rdata;

  rott_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_WORKERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wentry),
    .re_i    (pop_o),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    cur = rd_entry;
    if (!vld_q[idx]) begin
      cur.epoch = RESET_EPOCH;
      cur.gen   = RESET_GEN;
      cur.owner = 8'(idx);
    end
  end

  assign sane = (cur.epoch != 64'd0) && !cur.epoch[0] && (cur.owner < MaxW) &&
                (cur.gen != 32'd0);
  assign match = (cur.owner == req_q.tok_owner) && (cur.gen == req_q.tok_gen) &&
                 (cur.epoch == req_q.tok_epoch);
  assign next_epoch = req_q.tok_epoch + EPOCH_STEP;

  always_comb begin
    wentry.epoch = next_epoch;
    wentry.gen   = req_q.new_gen;
    wentry.owner = req_q.new_owner;
  end

  always_comb begin
    res_d = '0;
    unique case (req_q.kind)
      KIND_READ: begin
        if (sane) begin
          res_d.ok    = 1'b1;
          res_d.ring  = req_q.ring;
          res_d.owner = cur.owner;
          res_d.gen   = cur.gen;
          res_d.epoch = cur.epoch;
        end
      end
      KIND_CHECK: begin
        res_d.ok = sane && match;
      end
      KIND_XFER: begin
        if (match) begin
          res_d.ok    = 1'b1;
          res_d.ring  = req_q.ring;
          res_d.owner = req_q.new_owner;
          res_d.gen   = req_q.new_gen;
          res_d.epoch = next_epoch;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  assign we = (state_q == ST_EXEC) && out_free && (req_q.kind == KIND_XFER) && match;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_tready_i;
    vld_d     = vld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (we) begin
      vld_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q <= req_i;
    end
    if ((state_q == ST_EXEC) && out_free) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign res_o      = res_q;

  `ROTT_ASSERT(a_exec_holds, clk_i, rst_ni, (state_q == ST_EXEC) && !out_free |=> (state_q == ST_EXEC), "engine left a stalled item")
  `ROTT_ASSERT(a_valid_from_exec, clk_i, rst_ni, $rose(m_valid_q) |-> ($past(state_q) == ST_EXEC), "result without an executed item")
  `ROTT_ASSERT(a_write_marks_valid, clk_i, rst_ni, we |=> vld_q[$past(idx)], "written entry not marked valid")

endmodule

// File: rtl/ring_ownership_token_table_core.sv
// Top level of the ring ownership token table.
// Depends on rott_pkg, rott_front, rott_fifo and rott_back.
//
//  channel   | dir | tdata (low bit up)                                | tuser
//  ----------+-----+---------------------------------------------------+--------
//  s_axis    | in  | ring, token_ring, token_owner, token_generation,  | action
//            |     | token_epoch, new_owner, new_generation (160 b)    |
//  m_axis    | out | out_ring, out_owner, out_generation, out_epoch    | ok
//            |     | (112 b)                                           |
//
// Table engine: idle pops an item and issues the registered RAM read; exec
// compares, updates and loads the result register; only idle pops a new item.
// Reset clears entry valid bits; invalid entries read as owner i, generation 1,
// epoch 2. No clearing pass. A two-entry queue decouples intake from the engine;
// the engine holds its item while the result register is full and not taken.
module ring_ownership_token_table_core
  import rott_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // ring, token_ring, token_owner, token_generation, token_epoch, new_owner,
  // new_generation
  input  logic [159:0] s_axis_tdata_i,
  // action
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_ring, out_owner, out_generation, out_epoch
  output logic [111:0] m_axis_tdata_o,
  // ok
  output logic         m_axis_tuser_o
);

  req_t push_req;
  req_t head_req;
  res_t res;
  logic push;
  logic pop;
  logic full;
  logic empty;

  rott_front #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .full_i     (full),
    .s_tready_o (s_axis_tready_o),
    .push_o     (push),
    .req_o      (push_req)
  );

  rott_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .full_o  (full),
    .pop_i   (pop),
    .req_o   (head_req),
    .empty_o (empty)
  );

  rott_back #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .req_i      (head_req),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {res.epoch, res.gen, res.owner, res.ring};
  assign m_axis_tuser_o = res.ok;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for ring_ownership_token_table_core.
// Depends on rott_pkg and the core RTL. Drives read, check and transfer
// requests and checks every response against an in-bench table model.
`timescale 1ns / 100ps

module testbench;
  import rott_pkg::*;

  localparam int unsigned MaxWorkers = 8;
  localparam int unsigned IdxW       = $clog2(MaxWorkers);
  localparam logic [7:0]  RingLimit  = 8'(MaxWorkers);
  localparam logic [1:0]  ActUnused  = 2'd3;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned RandomOps  = 800;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  ring;
    logic [7:0]  tok_ring;
    logic [7:0]  tok_owner;
    logic [31:0] tok_gen;
    logic [63:0] tok_epoch;
    logic [7:0]  new_owner;
    logic [31:0] new_gen;
  } op_t;

  typedef entry_t [MaxWorkers-1:0] table_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic         s_valid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_ready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tuser;

  op_t         cur_op = '0;
  op_t         order_q[$];
  res_t        results_due[$];
  table_t      plan_tbl;
  table_t      live_tbl;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_cnt = 0;

  // ring, token_ring, token_owner, token_generation, token_epoch, new_owner,
  // new_generation
  assign s_axis_tdata = {cur_op.new_gen, cur_op.new_owner, cur_op.tok_epoch,
                         cur_op.tok_gen, cur_op.tok_owner, cur_op.tok_ring,
                         cur_op.ring};
  // action
  assign s_axis_tuser = cur_op.action;

  ring_ownership_token_table_core #(
    .MAX_WORKERS(MaxWorkers)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic table_t reset_table();
    table_t tbl;
    for (int i = 0; i < MaxWorkers; i++) begin
      tbl[IdxW'(i)].owner = 8'(i);
      tbl[IdxW'(i)].gen   = RESET_GEN;
      tbl[IdxW'(i)].epoch = RESET_EPOCH;
    end
    return tbl;
  endfunction

  function automatic bit entry_valid(input entry_t ent);
    return ent.epoch != '0 && !ent.epoch[0] && ent.owner < RingLimit && ent.gen != '0;
  endfunction

  function automatic res_t apply_op(input op_t op, inout table_t tbl);
    res_t   res;
    entry_t ent;
    res = '0;
    case (op.action)
      ACT_READ: begin
        if (op.ring < RingLimit) begin
          ent = tbl[op.ring[IdxW-1:0]];
          if (entry_valid(ent)) begin
            res.ok    = 1'b1;
            res.ring  = op.ring;
            res.owner = ent.owner;
            res.gen   = ent.gen;
            res.epoch = ent.epoch;
          end
        end
      end
      ACT_CHECK: begin
        if (op.tok_ring < RingLimit) begin
          ent = tbl[op.tok_ring[IdxW-1:0]];
          if (entry_valid(ent) && ent.owner == op.tok_owner && ent.gen == op.tok_gen &&
              ent.epoch == op.tok_epoch)
            res.ok = 1'b1;
        end
      end
      ACT_XFER: begin
        if (op.ring < RingLimit && op.tok_ring == op.ring && op.new_owner < RingLimit &&
            op.new_gen != '0 && !op.tok_epoch[0] && op.tok_epoch <= EPOCH_LIMIT) begin
          ent = tbl[op.ring[IdxW-1:0]];
          if (ent.epoch == op.tok_epoch && ent.owner == op.tok_owner &&
              ent.gen == op.tok_gen) begin
            ent.owner = op.new_owner;
            ent.gen   = op.new_gen;
            ent.epoch = op.tok_epoch + EPOCH_STEP;
            tbl[op.ring[IdxW-1:0]] = ent;
            res.ok    = 1'b1;
            res.ring  = op.ring;
            res.owner = ent.owner;
            res.gen   = ent.gen;
            res.epoch = ent.epoch;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic op_t mk_op(input logic [1:0] action, input logic [7:0] ring,
                                input logic [7:0] tok_ring, input logic [7:0] tok_owner,
                                input logic [31:0] tok_gen, input logic [63:0] tok_epoch,
                                input logic [7:0] new_owner, input logic [31:0] new_gen);
    op_t op;
    op.action    = action;
    op.ring      = ring;
    op.tok_ring  = tok_ring;
    op.tok_owner = tok_owner;
    op.tok_gen   = tok_gen;
    op.tok_epoch = tok_epoch;
    op.new_owner = new_owner;
    op.new_gen   = new_gen;
    return op;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_gen_nz();
    logic [31:0] g;
    g = $urandom;
    return (g == '0) ? 32'd1 : g;
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic queue_op(input op_t op);
    void'(apply_op(op, plan_tbl));
    order_q.push_back(op);
  endtask

  task automatic drain();
    while (order_q.size() != 0 || s_valid || results_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // driver: present one transaction at a time, hold until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!s_valid || in_taken) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_valid  <= 1'b0;
        end else if (order_q.size() != 0) begin
          cur_op   <= order_q.pop_front();
          s_valid  <= 1'b1;
          send_gap <= draw_wait(send_burst);
          if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // response side backpressure
  always @(negedge clk) begin : recv_side
    int unsigned w;
    if (rst_n) begin
      if (out_taken) begin
        w = draw_wait(recv_burst);
        m_ready   <= (w == 0);
        recv_wait <= (w == 0) ? 0 : w - 1;
        if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // monitor: check responses first, then predict for the request taken
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      in_taken  <= s_valid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_ready;
      if (m_axis_tvalid && m_ready) begin
        if (results_due.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          want = results_due.pop_front();
          check_field("ok", 64'(want.ok), 64'(m_axis_tuser));
          check_field("out_ring", 64'(want.ring), 64'(m_axis_tdata[7:0]));
          check_field("out_owner", 64'(want.owner), 64'(m_axis_tdata[15:8]));
          check_field("out_generation", 64'(want.gen), 64'(m_axis_tdata[47:16]));
          check_field("out_epoch", want.epoch, m_axis_tdata[111:48]);
        end
      end
      if (s_valid && s_axis_tready) results_due.push_back(apply_op(cur_op, live_tbl));
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_t         op;
    entry_t      ent;
    logic [7:0]  r;
    int unsigned sel;
    plan_tbl = reset_table();
    live_tbl = reset_table();

    queue_op(mk_op(ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 64'd0, 8'd0, 32'd0));
    queue_op(mk_op(ACT_READ, 8'd7, 8'd0, 8'd0, 32'd0, 64'd0, 8'd0, 32'd0));
    queue_op(mk_op(ACT_READ, 8'd8, 8'd0, 8'd0, 32'd0, 64'd0, 8'd0, 32'd0));
    queue_op(mk_op(ACT_READ, 8'hFF, 8'hFF, 8'hFF, '1, '1, 8'hFF, '1));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd3, 8'd3, RESET_GEN, RESET_EPOCH, 8'd0, 32'd0));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd8, 8'd0, RESET_GEN, RESET_EPOCH, 8'd0, 32'd0));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd3, 8'd4, RESET_GEN, RESET_EPOCH, 8'd0, 32'd0));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd3, 8'd3, 32'd2, RESET_EPOCH, 8'd0, 32'd0));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd3, 8'd3, RESET_GEN, 64'd4, 8'd0, 32'd0));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd3, RESET_GEN, RESET_EPOCH, 8'd7, '1));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd3, RESET_GEN, RESET_EPOCH, 8'd7, '1));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd2, 8'd7, '1, 64'd4, 8'd1, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'd4, 8'd8, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'd4, 8'hFF, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'd4, 8'd1, 32'd0));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'd5, 8'd1, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'd1, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, '1, 8'd1, 32'd5));
    queue_op(mk_op(ACT_XFER, 8'hFF, 8'hFF, 8'd7, '1, 64'd4, 8'd1, 32'd5));
    queue_op(mk_op(ActUnused, 8'd3, 8'd3, 8'd7, '1, 64'd4, 8'd1, 32'd5));
    queue_op(mk_op(ACT_READ, 8'd3, 8'd0, 8'd0, 32'd0, 64'd0, 8'd0, 32'd0));
    queue_op(mk_op(ACT_XFER, 8'd0, 8'd0, 8'd0, RESET_GEN, RESET_EPOCH, 8'd0, 32'd1));
    queue_op(mk_op(ACT_CHECK, 8'd0, 8'd3, 8'd7, '1, 64'd4, 8'd0, 32'd0));
    queue_op(mk_op(ACT_XFER, 8'd3, 8'd3, 8'd7, '1, 64'd4, 8'd0, 32'd1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < RandomOps; n++) begin
      if (n == RandomOps / 2) drain();
      r   = 8'($urandom_range(0, MaxWorkers - 1));
      ent = plan_tbl[r[IdxW-1:0]];
      op  = mk_op(ACT_XFER, r, r, ent.owner, ent.gen, ent.epoch,
                  8'($urandom_range(0, MaxWorkers - 1)), rand_gen_nz());
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
      end else if (sel < 55) begin
        op.action = ACT_CHECK;
      end else if (sel < 65) begin
        op.action = ACT_READ;
      end else if (sel < 82) begin
        // break one field of an otherwise valid request
        if ($urandom_range(0, 2) == 0) op.action = ACT_CHECK;
        case ($urandom_range(0, 6))
          0: begin
            op.ring     = 8'($urandom_range(MaxWorkers, 255));
            op.tok_ring = op.ring;
          end
          1: op.tok_ring  = op.tok_ring ^ (8'd1 << $urandom_range(0, 7));
          2: op.tok_owner = op.tok_owner ^ (8'd1 << $urandom_range(0, 7));
          3: op.tok_gen   = op.tok_gen ^ (32'd1 << $urandom_range(0, 31));
          4: op.tok_epoch = op.tok_epoch ^ (64'd1 << $urandom_range(0, 63));
          5: op.new_owner = 8'($urandom_range(MaxWorkers, 255));
          default: op.new_gen = '0;
        endcase
      end else begin
        op = mk_op(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom, rand64(), 8'($urandom), $urandom);
        if ($urandom_range(0, 1) == 0) op.ring = r;
        if ($urandom_range(0, 1) == 0) op.tok_ring = op.ring;
      end
      queue_op(op);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
